@@ src/text_console_writer_assert.svh @@
// Assertion macros shared by the console writer modules.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define TCW_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define TCW_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ src/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Types, codes and cell helpers shared by the text console writer modules.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam logic [1:0] ACT_PUT   = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_RETURN  = 8'd13;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	localparam logic [3:0] RESET_FORE = 4'hF;
	localparam logic [3:0] RESET_BACK = 4'h0;
	localparam logic [15:0] RESET_BLANK = {RESET_BACK, RESET_FORE, CH_SPACE};

	localparam logic CFG_FORE = 1'b0;
	localparam logic CFG_BACK = 1'b1;

	localparam int POS_W  = 11;
	localparam int CELL_W = 16;

	typedef enum logic [2:0] {
		OP_PUT,
		OP_NEWLINE,
		OP_RETURN,
		OP_CLEAR,
		OP_READ,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
	} cmd_t;

	typedef struct packed {
		logic [3:0] fore;
		logic [3:0] back;
	} color_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_DRAIN,
		ST_BLANK
	} back_state_t;

	function automatic logic [15:0] make_cell(color_t colors, logic [7:0] ch);
		make_cell = {colors.back, colors.fore, ch};
	endfunction

endpackage

@@ src/tcw_front.sv @@
// ----------------------------------------------------------------------------
// tcw_front
// Classifies an incoming request into a back-end command and a cell address.
// ----------------------------------------------------------------------------
module tcw_front #(
	parameter int NUM_ROWS = 25,
	parameter int NUM_COLS = 80,
	parameter int AW       = 11
) (
	input  logic [1:0]      action,
	input  logic [7:0]      char_code,
	input  logic [4:0]      read_row,
	input  logic [6:0]      read_col,
	output tcw_pkg::cmd_t   cmd,
	output logic [AW-1:0]   addr
);

	logic in_grid;

	assign in_grid = (32'(read_row) < NUM_ROWS) && (32'(read_col) < NUM_COLS);

	// Only meaningful for reads inside the grid, where the sum fits AW bits.
	assign addr = AW'(read_row) * AW'(NUM_COLS) + AW'(read_col);

	always_comb begin
		cmd.ch = char_code;
		case (action)
			tcw_pkg::ACT_PUT: begin
				if (char_code == tcw_pkg::CH_NEWLINE) begin
					cmd.op = tcw_pkg::OP_NEWLINE;
				end else if (char_code == tcw_pkg::CH_RETURN) begin
					cmd.op = tcw_pkg::OP_RETURN;
				end else begin
					cmd.op = tcw_pkg::OP_PUT;
				end
			end
			tcw_pkg::ACT_CLEAR: cmd.op = tcw_pkg::OP_CLEAR;
			tcw_pkg::ACT_READ: begin
				cmd.op = in_grid ? tcw_pkg::OP_READ : tcw_pkg::OP_NOP;
			end
			default: cmd.op = tcw_pkg::OP_NOP;
		endcase
	end

endmodule

@@ src/tcw_queue.sv @@
// ----------------------------------------------------------------------------
// tcw_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module tcw_queue #(
	parameter int W = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         full,
	output logic         not_empty
);

	logic [W-1:0] entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ src/tcw_back.sv @@
// ----------------------------------------------------------------------------
// tcw_back
// Executes commands against the cell memory, keeps the cursor and issues
// one result per command. Scrolls, clears and the post-reset fill sweep the
// memory one cell per cycle.
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_back #(
	parameter int NUM_ROWS = 25,
	parameter int NUM_COLS = 80,
	parameter int AW       = 11
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tcw_pkg::color_t             colors,
	input  logic                        cmd_valid,
	input  tcw_pkg::cmd_t               cmd,
	input  logic [AW-1:0]               cmd_addr,
	output logic                        pop,
	output logic                        init_busy,
	output logic                        done,
	output logic [tcw_pkg::POS_W-1:0]   cursor_pos,
	output logic [tcw_pkg::CELL_W-1:0]  cell_data
);

	localparam int CELLS = NUM_ROWS * NUM_COLS;
	localparam int RW    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
	localparam int CW    = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;

	localparam logic [AW-1:0] LAST_CELL      = AW'(CELLS - 1);
	localparam logic [AW-1:0] LAST_ROW_START = AW'(CELLS - NUM_COLS);
	localparam logic [AW-1:0] ROW_STRIDE     = AW'(NUM_COLS);
	localparam logic [RW-1:0] LAST_ROW       = RW'(NUM_ROWS - 1);
	localparam logic [CW-1:0] LAST_COL       = CW'(NUM_COLS - 1);

	tcw_pkg::back_state_t state_q, state_d;

	logic [RW-1:0] row_q, row_d;
	logic [CW-1:0] col_q, col_d;
	logic [AW-1:0] lin_q, lin_d;
	logic [AW-1:0] idx_q, idx_d;

	logic          cp_vld_s1, cp_vld_d;
	logic [AW-1:0] cp_addr_s1, cp_addr_d;

	logic [15:0]   mem [CELLS];
	logic [15:0]   rd_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [15:0]   mem_wd;
	logic [AW-1:0] mem_ra;

	logic          emit;
	logic [15:0]   emit_data;
	logic          done_q;
	logic [tcw_pkg::POS_W-1:0]  pos_q;
	logic [tcw_pkg::CELL_W-1:0] data_q;
	logic [15:0]   blank;

	assign blank     = tcw_pkg::make_cell(colors, tcw_pkg::CH_SPACE);
	assign init_busy = (state_q == tcw_pkg::ST_INIT);
	assign done       = done_q;
	assign cursor_pos = pos_q;
	assign cell_data  = data_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	always_comb begin
		state_d   = state_q;
		row_d     = row_q;
		col_d     = col_q;
		lin_d     = lin_q;
		idx_d     = idx_q;
		cp_vld_d  = 1'b0;
		cp_addr_d = idx_q - ROW_STRIDE;
		mem_ra    = idx_q;
		emit      = 1'b0;
		emit_data = '0;
		pop       = 1'b0;

		// A copy read last cycle is written one row higher this cycle.
		mem_we = cp_vld_s1;
		mem_wa = cp_addr_s1;
		mem_wd = rd_q;

		case (state_q)
			tcw_pkg::ST_INIT: begin
				mem_we = 1'b1;
				mem_wa = idx_q;
				mem_wd = tcw_pkg::RESET_BLANK;
				if (idx_q == LAST_CELL) begin
					idx_d   = '0;
					state_d = tcw_pkg::ST_IDLE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			tcw_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					pop = 1'b1;
					case (cmd.op)
						tcw_pkg::OP_PUT: begin
							mem_we = 1'b1;
							mem_wa = lin_q;
							mem_wd = tcw_pkg::make_cell(colors, cmd.ch);
							if (col_q == LAST_COL) begin
								col_d = '0;
								if (row_q == LAST_ROW) begin
									lin_d   = LAST_ROW_START;
									idx_d   = ROW_STRIDE;
									state_d = tcw_pkg::ST_SCROLL;
								end else begin
									row_d = row_q + 1'b1;
									lin_d = lin_q + 1'b1;
									emit  = 1'b1;
								end
							end else begin
								col_d = col_q + 1'b1;
								lin_d = lin_q + 1'b1;
								emit  = 1'b1;
							end
						end
						tcw_pkg::OP_NEWLINE: begin
							col_d = '0;
							if (row_q == LAST_ROW) begin
								lin_d   = LAST_ROW_START;
								idx_d   = ROW_STRIDE;
								state_d = tcw_pkg::ST_SCROLL;
							end else begin
								row_d = row_q + 1'b1;
								lin_d = lin_q - AW'(col_q) + ROW_STRIDE;
								emit  = 1'b1;
							end
						end
						tcw_pkg::OP_RETURN: begin
							col_d = '0;
							lin_d = lin_q - AW'(col_q);
							emit  = 1'b1;
						end
						tcw_pkg::OP_CLEAR: begin
							row_d   = '0;
							col_d   = '0;
							lin_d   = '0;
							idx_d   = '0;
							state_d = tcw_pkg::ST_BLANK;
						end
						tcw_pkg::OP_READ: begin
							mem_ra  = cmd_addr;
							state_d = tcw_pkg::ST_READ;
						end
						default: emit = 1'b1;
					endcase
				end
			end
			tcw_pkg::ST_READ: begin
				emit      = 1'b1;
				emit_data = rd_q;
				state_d   = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_SCROLL: begin
				mem_ra    = idx_q;
				cp_vld_d  = 1'b1;
				cp_addr_d = idx_q - ROW_STRIDE;
				if (idx_q == LAST_CELL) begin
					state_d = tcw_pkg::ST_DRAIN;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			tcw_pkg::ST_DRAIN: begin
				idx_d   = LAST_ROW_START;
				state_d = tcw_pkg::ST_BLANK;
			end
			tcw_pkg::ST_BLANK: begin
				mem_we = 1'b1;
				mem_wa = idx_q;
				mem_wd = blank;
				if (idx_q == LAST_CELL) begin
					emit    = 1'b1;
					state_d = tcw_pkg::ST_IDLE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			default: state_d = tcw_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tcw_pkg::ST_INIT;
			row_q     <= '0;
			col_q     <= '0;
			lin_q     <= '0;
			idx_q     <= '0;
			cp_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			row_q     <= row_d;
			col_q     <= col_d;
			lin_q     <= lin_d;
			idx_q     <= idx_d;
			cp_vld_s1 <= cp_vld_d;
			done_q    <= emit;
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_s1 <= cp_addr_d;
		if (emit) begin
			pos_q  <= tcw_pkg::POS_W'(lin_d);
			data_q <= emit_data;
		end
	end

	`TCW_ASSERT_ALWAYS(a_lin_match, 32'(lin_q) == 32'(row_q) * NUM_COLS + 32'(col_q), "cursor index out of step with row and column")
	`TCW_ASSERT_ALWAYS(a_cursor_range, (32'(col_q) < NUM_COLS) && (32'(row_q) < NUM_ROWS), "cursor outside the grid")
	`TCW_ASSERT_IMPLIES(a_init_quiet, state_q == tcw_pkg::ST_INIT, !done_q && !pop, "result or pop during the reset fill")
	`TCW_ASSERT_IMPLIES(a_copy_window, cp_vld_s1, (state_q == tcw_pkg::ST_SCROLL) || (state_q == tcw_pkg::ST_DRAIN), "scroll copy write outside a scroll")

endmodule

@@ src/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// Text console of NUM_ROWS by NUM_COLS character cells with a cursor.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken at a rising edge with start high and busy low; action
// selects put character, clear screen or read cell. Every request produces
// exactly one result: done is high for one cycle with cursor_pos and
// cell_data valid, and the receiver cannot hold it off.
// Requests enter a two-entry queue, so busy only rises while the queue is
// full or during the fill after reset.
// A put, carriage return or ignored request passes the queue and the done
// register; a read also passes the ST_READ state. A scroll copies the rows
// up and blanks the last row, and a clear blanks every cell, one cell copied
// or blanked per cycle through the single write port. Sustained rate is one
// put per cycle without scrolls. After reset the cell memory is filled with
// blanks, one cell per cycle, with busy high; color writes are taken meanwhile.
// Color registers are written through cfg_we, cfg_index and cfg_data.
// ----------------------------------------------------------------------------
module text_console_writer #(
	parameter int NUM_ROWS = 25,
	parameter int NUM_COLS = 80
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [7:0]  char_code,
	input  logic [4:0]  read_row,
	input  logic [6:0]  read_col,
	output logic        done,
	output logic [10:0] cursor_pos,
	output logic [15:0] cell_data,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [3:0]  cfg_data
);

	localparam int AW   = $clog2(NUM_ROWS * NUM_COLS);
	localparam int CMDW = $bits(tcw_pkg::cmd_t);
	localparam int QW   = CMDW + AW;

	tcw_pkg::color_t colors_q;
	tcw_pkg::cmd_t   front_cmd;
	tcw_pkg::cmd_t   back_cmd;
	logic [AW-1:0]   front_addr;
	logic [QW-1:0]   q_out;
	logic            q_push;
	logic            q_pop;
	logic            q_full;
	logic            q_not_empty;
	logic            init_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colors_q.fore <= tcw_pkg::RESET_FORE;
			colors_q.back <= tcw_pkg::RESET_BACK;
		end else if (cfg_we) begin
			case (cfg_index)
				tcw_pkg::CFG_FORE: colors_q.fore <= cfg_data;
				tcw_pkg::CFG_BACK: colors_q.back <= cfg_data;
				default: colors_q <= colors_q;
			endcase
		end
	end

	assign busy   = q_full | init_busy;
	assign q_push = start & ~busy;

	tcw_front #(
		.NUM_ROWS (NUM_ROWS),
		.NUM_COLS (NUM_COLS),
		.AW       (AW)
	) u_front (
		.action    (action),
		.char_code (char_code),
		.read_row  (read_row),
		.read_col  (read_col),
		.cmd       (front_cmd),
		.addr      (front_addr)
	);

	tcw_queue #(
		.W (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({front_cmd, front_addr}),
		.pop       (q_pop),
		.pop_data  (q_out),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	assign back_cmd = tcw_pkg::cmd_t'(q_out[QW-1:AW]);

	tcw_back #(
		.NUM_ROWS (NUM_ROWS),
		.NUM_COLS (NUM_COLS),
		.AW       (AW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.colors     (colors_q),
		.cmd_valid  (q_not_empty),
		.cmd        (back_cmd),
		.cmd_addr   (q_out[AW-1:0]),
		.pop        (q_pop),
		.init_busy  (init_busy),
		.done       (done),
		.cursor_pos (cursor_pos),
		.cell_data  (cell_data)
	);

endmodule

@@ dv/text_console_writer_checker.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_checker
// Watches the request, result and color ports of the console writer, keeps
// its own copy of the screen, cursor and colors, and compares every result
// against the oldest predicted one.
// ----------------------------------------------------------------------------
module text_console_writer_checker #(
	parameter int NUM_ROWS = 25,
	parameter int NUM_COLS = 80
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  action,
	input  logic [7:0]  char_code,
	input  logic [4:0]  read_row,
	input  logic [6:0]  read_col,
	input  logic        done,
	input  logic [10:0] cursor_pos,
	input  logic [15:0] cell_data,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CELLS = NUM_ROWS * NUM_COLS;

	typedef struct packed {
		logic [tcw_pkg::POS_W-1:0]  pos;
		logic [tcw_pkg::CELL_W-1:0] data;
	} reply_t;

	logic [tcw_pkg::CELL_W-1:0] screen [CELLS];
	int                cur_row;
	int                cur_col;
	logic [3:0]        fg;
	logic [3:0]        bg;
	reply_t            replies_due [$];

	function automatic logic [tcw_pkg::CELL_W-1:0] colored(logic [7:0] ch);
		return {bg, fg, ch};
	endfunction

	function automatic void wipe_screen();
		for (int i = 0; i < CELLS; i++)
			screen[i] = colored(tcw_pkg::CH_SPACE);
	endfunction

	function automatic void scroll_screen();
		for (int i = NUM_COLS; i < CELLS; i++)
			screen[i - NUM_COLS] = screen[i];
		for (int i = CELLS - NUM_COLS; i < CELLS; i++)
			screen[i] = colored(tcw_pkg::CH_SPACE);
	endfunction

	function automatic void line_feed();
		cur_row++;
		if (cur_row >= NUM_ROWS) begin
			cur_row = NUM_ROWS - 1;
			scroll_screen();
		end
	endfunction

	// Applies one request to the shadow console and returns the result it gives.
	function automatic reply_t console_step(logic [1:0] act, logic [7:0] ch,
			logic [4:0] row, logic [6:0] col);
		reply_t r;
		r.data = '0;
		case (act)
			tcw_pkg::ACT_PUT: begin
				if (ch == tcw_pkg::CH_NEWLINE) begin
					cur_col = 0;
					line_feed();
				end else if (ch == tcw_pkg::CH_RETURN) begin
					cur_col = 0;
				end else begin
					screen[cur_row * NUM_COLS + cur_col] = colored(ch);
					cur_col++;
					if (cur_col >= NUM_COLS) begin
						cur_col = 0;
						line_feed();
					end
				end
			end
			tcw_pkg::ACT_CLEAR: begin
				wipe_screen();
				cur_row = 0;
				cur_col = 0;
			end
			tcw_pkg::ACT_READ: begin
				if (row < NUM_ROWS && col < NUM_COLS)
					r.data = screen[row * NUM_COLS + col];
			end
			default: begin
			end
		endcase
		r.pos = tcw_pkg::POS_W'(cur_row * NUM_COLS + cur_col);
		return r;
	endfunction

	function automatic void flag(string what, int unsigned want, int unsigned got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			fg = tcw_pkg::RESET_FORE;
			bg = tcw_pkg::RESET_BACK;
			cur_row = 0;
			cur_col = 0;
			wipe_screen();
			replies_due.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (done) begin
				if (replies_due.size() == 0) begin
					flag("unrequested result, cursor_pos", 0, cursor_pos);
				end else begin
					want = replies_due.pop_front();
					if (cursor_pos !== want.pos)
						flag("cursor_pos", want.pos, cursor_pos);
					if (cell_data !== want.data)
						flag("cell_data", want.data, cell_data);
				end
			end
			if (start && !busy)
				replies_due.push_back(console_step(action, char_code, read_row, read_col));
			if (cfg_we) begin
				case (cfg_index)
					tcw_pkg::CFG_FORE: fg = cfg_data;
					tcw_pkg::CFG_BACK: bg = cfg_data;
					default: begin
					end
				endcase
			end
			outstanding = replies_due.size();
		end
	end

endmodule

@@ dv/text_console_writer_tb.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Drives put, clear, read and unused requests into the console writer in
// three color settings and sender pacings, with a checker alongside that
// predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_ROWS = 25;
	localparam int NUM_COLS = 80;
	localparam int CELLS    = NUM_ROWS * NUM_COLS;
	// Quiet margin after the last result before the colors change.
	localparam int SETTLE   = CELLS + 100;
	// The one action code that the block ignores.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  action;
	logic [7:0]  char_code;
	logic [4:0]  read_row;
	logic [6:0]  read_col;
	logic        done;
	logic [10:0] cursor_pos;
	logic [15:0] cell_data;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [3:0]  cfg_data;
	int          mismatches;
	int          outstanding;

	int sent;
	int idle_pct;

	always #6 clk = ~clk;

	text_console_writer #(
		.NUM_ROWS(NUM_ROWS),
		.NUM_COLS(NUM_COLS)
	) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.char_code(char_code), .read_row(read_row), .read_col(read_col), .done(done),
		.cursor_pos(cursor_pos), .cell_data(cell_data), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	text_console_writer_checker #(
		.NUM_ROWS(NUM_ROWS),
		.NUM_COLS(NUM_COLS)
	) checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.char_code(char_code), .read_row(read_row), .read_col(read_col), .done(done),
		.cursor_pos(cursor_pos), .cell_data(cell_data), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .mismatches(mismatches),
		.outstanding(outstanding)
	);

	// Presents one request, first idling while a random draw below a hundred
	// falls under idle_pct, and returns at the edge that accepts it.
	task automatic issue(logic [1:0] act, logic [7:0] ch, logic [4:0] row, logic [6:0] col);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start     <= 1'b1;
		action    <= act;
		char_code <= ch;
		read_row  <= row;
		read_col  <= col;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic put_char(logic [7:0] ch);
		issue(tcw_pkg::ACT_PUT, ch, 5'($urandom_range(31)), 7'($urandom_range(127)));
	endtask

	task automatic read_cell(int row, int col);
		issue(tcw_pkg::ACT_READ, 8'($urandom_range(255)), 5'(row), 7'(col));
	endtask

	function automatic logic [7:0] text_char();
		return ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(32, 126));
	endfunction

	task automatic drain();
		start <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_colors(logic [3:0] fore, logic [3:0] back);
		cfg_we    <= 1'b1;
		cfg_index <= tcw_pkg::CFG_FORE;
		cfg_data  <= fore;
		@(posedge clk);
		cfg_index <= tcw_pkg::CFG_BACK;
		cfg_data  <= back;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Mostly lines of text, newline runs that push the screen into scrolling,
	// and reads of cells, with occasional clears; the rest is random noise.
	task automatic random_requests(int goal);
		int pick;
		int len;
		while (sent < goal) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				len = ($urandom_range(4) == 0) ? $urandom_range(60, 170) : $urandom_range(1, 40);
				repeat (len) put_char(text_char());
				pick = $urandom_range(9);
				if (pick < 8)
					put_char(tcw_pkg::CH_NEWLINE);
				else if (pick == 8)
					put_char(tcw_pkg::CH_RETURN);
			end else if (pick < 65) begin
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(7) != 0)
						read_cell($urandom_range(NUM_ROWS - 1), $urandom_range(NUM_COLS - 1));
					else if ($urandom_range(1) == 0)
						read_cell($urandom_range(NUM_ROWS, 31), $urandom_range(127));
					else
						read_cell($urandom_range(31), $urandom_range(NUM_COLS, 127));
				end
			end else if (pick < 70) begin
				repeat ($urandom_range(5, 30)) put_char(tcw_pkg::CH_NEWLINE);
			end else if (pick < 72) begin
				issue(tcw_pkg::ACT_CLEAR, 8'($urandom_range(255)), 5'($urandom_range(31)),
					7'($urandom_range(127)));
			end else begin
				issue(2'($urandom_range(3)), 8'($urandom_range(255)), 5'($urandom_range(31)),
					7'($urandom_range(127)));
			end
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		action    <= tcw_pkg::ACT_PUT;
		char_code <= '0;
		read_row  <= '0;
		read_col  <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= tcw_pkg::CFG_FORE;
		cfg_data  <= '0;
		sent = 0;
		idle_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// Let the blank fill after reset finish before touching the colors.
		do @(posedge clk); while (busy);
		set_colors(tcw_pkg::RESET_FORE, tcw_pkg::RESET_BACK);

		read_cell(0, 0);
		read_cell(NUM_ROWS - 1, NUM_COLS - 1);
		read_cell(31, 127);
		read_cell(NUM_ROWS, 0);
		read_cell(0, NUM_COLS);
		issue(ACT_UNUSED, 8'hFF, 5'd31, 7'd127);
		put_char(8'h00);
		put_char(8'hFF);
		put_char(8'h80);
		put_char(8'h7F);
		read_cell(0, 1);
		read_cell(0, 2);
		put_char(tcw_pkg::CH_RETURN);
		put_char("A");
		read_cell(0, 0);
		put_char(tcw_pkg::CH_NEWLINE);
		put_char("z");
		read_cell(1, 0);
		issue(tcw_pkg::ACT_CLEAR, 8'h00, 5'd0, 7'd0);
		read_cell(0, 0);
		read_cell(0, 3);

		idle_pct = 36;
		random_requests(430);
		drain();
		set_colors(4'h0, 4'hF);
		idle_pct = 68;
		random_requests(850);
		drain();
		set_colors(4'($urandom_range(15)), 4'($urandom_range(15)));
		idle_pct = 0;
		random_requests(1250);
		drain();

		if (mismatches == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#150_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
